// ===== rtl/box_blur_3x3_rgb_macros.svh =====
// Assertion macros used by the checker file of box_blur_3x3_rgb.
// Depends on nothing; included by bare file name.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define BB3_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define BB3_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bb3_pkg.sv =====
// Package for box_blur_3x3_rgb: sizes, register indexes and the queue word.
// Used by every module of the block; depends on nothing.
package bb3_pkg;

  // Geometry limits
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 12;
  localparam int PIX_W     = 24;

  // Effective geometry bounds
  localparam logic [CFG_W-1:0] MIN_DIM    = CFG_W'(3);
  localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);

  // Front to back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Floor of sum/9 for sums up to 2295: (sum * 7282) >> 16
  localparam int SUM_W    = 12;
  localparam int RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);
  localparam int RECIP_SH = 16;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // One pixel word handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] above2;   // line two up
    logic [PIX_W-1:0] above1;   // line one up
    logic [PIX_W-1:0] pix;      // current pixel
    logic             emit;     // interior pixel: produce a result
    logic [ROW_W-1:0] row;      // center row
    logic [COL_W-1:0] col;      // center column
    logic             eof;      // last interior result of the frame
  } q_word_t;

endpackage

// ===== rtl/bb3_front.sv =====
// Front part of box_blur_3x3_rgb: config registers, raster counters,
// line store memory with read bypass, and classification. Uses bb3_pkg.
module bb3_front (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_pix_blue,
  input  logic [7:0]                   in_pix_green,
  input  logic [7:0]                   in_pix_red,
  input  logic                         in_start_of_frame,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [0:0]                   cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]    cfg_data,
  // queue side
  input  logic [bb3_pkg::QCNT_W-1:0]   q_count,
  output logic                         push_valid,
  output bb3_pkg::q_word_t             push_word
);

  localparam int LW = 2 * bb3_pkg::PIX_W;

  logic [bb3_pkg::CFG_W-1:0] wid_r, hgt_r;
  logic [bb3_pkg::ROW_W-1:0] row_r;
  logic [bb3_pkg::COL_W-1:0] col_r;

  logic                      accept;
  logic [bb3_pkg::ROW_W-1:0] r_cur;
  logic [bb3_pkg::COL_W-1:0] c_cur;
  logic                      col_last, row_last, emit, eof;
  logic [bb3_pkg::ROW_W-1:0] row_nxt;
  logic [bb3_pkg::COL_W-1:0] col_nxt;
  logic [bb3_pkg::CFG_W-1:0] wid_nxt, hgt_nxt;

  // stage 1: line store read in flight
  logic                      s1_v_r;
  logic [bb3_pkg::COL_W-1:0] s1_idx_r;
  logic [bb3_pkg::PIX_W-1:0] s1_pix_r;
  logic                      s1_emit_r, s1_eof_r;
  logic [bb3_pkg::ROW_W-1:0] s1_row_r;
  logic [bb3_pkg::COL_W-1:0] s1_col_r;
  logic [LW-1:0]             rd_mem_r;
  logic                      byp_r;
  logic [LW-1:0]             byp_data_r;
  logic [LW-1:0]             s1_line;
  logic [LW-1:0]             wr_data;

  // {older line, newer line} per column
  logic [LW-1:0] line_mem [bb3_pkg::MAX_WIDTH];

  assign cfg_ready = 1'b1;

  // room for the word in stage 1 plus the one taken now
  assign in_ready = ({1'b0, q_count} + (bb3_pkg::QCNT_W+1)'(s1_v_r))
                    < (bb3_pkg::QCNT_W+1)'(bb3_pkg::QDEPTH);
  assign accept   = in_valid & in_ready;

  // clamp written geometry
  always_comb begin
    wid_nxt = cfg_data;
    if (cfg_data < bb3_pkg::MIN_DIM) wid_nxt = bb3_pkg::MIN_DIM;
    else if (cfg_data > bb3_pkg::WIDTH_MAX) wid_nxt = bb3_pkg::WIDTH_MAX;
    hgt_nxt = cfg_data;
    if (cfg_data < bb3_pkg::MIN_DIM) hgt_nxt = bb3_pkg::MIN_DIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_r <= bb3_pkg::RST_WIDTH;
      hgt_r <= bb3_pkg::RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bb3_pkg::cfg_reg_t'(cfg_index))
        bb3_pkg::REG_IMAGE_WIDTH:  wid_r <= wid_nxt;
        bb3_pkg::REG_IMAGE_HEIGHT: hgt_r <= hgt_nxt;
        default: ;
      endcase
    end
  end

  // position of the incoming pixel and its classification
  always_comb begin
    r_cur    = in_start_of_frame ? '0 : row_r;
    c_cur    = in_start_of_frame ? '0 : col_r;
    col_last = ({1'b0, c_cur} + bb3_pkg::CFG_W'(1)) >= wid_r;
    row_last = ({1'b0, r_cur} + (bb3_pkg::ROW_W+1)'(1)) >= {1'b0, hgt_r};
    emit     = (r_cur >= bb3_pkg::ROW_W'(2)) && (c_cur >= bb3_pkg::COL_W'(2))
               && (r_cur < hgt_r) && ({1'b0, c_cur} < wid_r);
    eof      = (r_cur == hgt_r - bb3_pkg::ROW_W'(1))
               && ({1'b0, c_cur} == wid_r - bb3_pkg::CFG_W'(1));
    col_nxt  = col_last ? '0 : c_cur + bb3_pkg::COL_W'(1);
    if (!col_last)     row_nxt = r_cur;
    else if (row_last) row_nxt = '0;
    else               row_nxt = r_cur + bb3_pkg::ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= accept;
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r  <= c_cur;
      s1_pix_r  <= {in_pix_red, in_pix_green, in_pix_blue};
      s1_emit_r <= emit;
      s1_eof_r  <= eof;
      s1_row_r  <= r_cur - bb3_pkg::ROW_W'(1);
      s1_col_r  <= c_cur - bb3_pkg::COL_W'(1);
    end
  end

  // line data seen by stage 1; write back shifts the column down one line
  assign s1_line = byp_r ? byp_data_r : rd_mem_r;
  assign wr_data = {s1_line[bb3_pkg::PIX_W-1:0], s1_pix_r};

  // line store: read on accept, write from stage 1, bypass same column
  always_ff @(posedge clk) begin
    if (s1_v_r) line_mem[s1_idx_r] <= wr_data;
    if (accept) begin
      rd_mem_r   <= line_mem[c_cur];
      byp_r      <= s1_v_r && (s1_idx_r == c_cur);
      byp_data_r <= wr_data;
    end
  end

  // word to the queue
  assign push_valid       = s1_v_r;
  assign push_word.above2 = s1_line[LW-1:bb3_pkg::PIX_W];
  assign push_word.above1 = s1_line[bb3_pkg::PIX_W-1:0];
  assign push_word.pix    = s1_pix_r;
  assign push_word.emit   = s1_emit_r;
  assign push_word.row    = s1_row_r;
  assign push_word.col    = s1_col_r;
  assign push_word.eof    = s1_eof_r;

endmodule

// ===== rtl/bb3_fifo.sv =====
// Short queue between front and back of box_blur_3x3_rgb.
// Holds bb3_pkg::q_word_t words; depth from bb3_pkg::QDEPTH.
module bb3_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  bb3_pkg::q_word_t            push_word,
  input  logic                        pop,
  output logic                        pop_valid,
  output bb3_pkg::q_word_t            pop_word,
  output logic [bb3_pkg::QCNT_W-1:0]  count
);

  bb3_pkg::q_word_t                 slot_r [bb3_pkg::QDEPTH];
  logic [bb3_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [bb3_pkg::QCNT_W-1:0]       cnt_r;
  logic                             do_pop;

  assign do_pop    = pop & (cnt_r != '0);
  assign pop_valid = (cnt_r != '0);
  assign pop_word  = slot_r[rd_ptr_r];
  assign count     = cnt_r;

  // pointers and fill count; the front never pushes into a full queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + bb3_pkg::QPTR_W'(1);
      if (do_pop)     rd_ptr_r <= rd_ptr_r + bb3_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + bb3_pkg::QCNT_W'(push_valid) - bb3_pkg::QCNT_W'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_valid) slot_r[wr_ptr_r] <= push_word;
  end

endmodule

// ===== rtl/bb3_back.sv =====
// Back part of box_blur_3x3_rgb: 3x3 window, per-channel sums,
// divide by nine and the output register. Uses bb3_pkg.
module bb3_back (
  input  logic                       clk,
  input  logic                       rst_n,
  // queue side
  input  logic                       pop_valid,
  input  bb3_pkg::q_word_t           pop_word,
  output logic                       pop,
  // result output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_mean_blue,
  output logic [7:0]                 out_mean_green,
  output logic [7:0]                 out_mean_red,
  output logic [bb3_pkg::ROW_W-1:0]  out_center_row,
  output logic [bb3_pkg::COL_W-1:0]  out_center_col,
  output logic                       out_end_of_frame
);

  localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  logic                      adv;
  logic [bb3_pkg::PIX_W-1:0] win_r [9];

  logic                      b1_v_r, b2_v_r, out_v_r;
  logic [bb3_pkg::ROW_W-1:0] b1_row_r, b2_row_r, out_row_r;
  logic [bb3_pkg::COL_W-1:0] b1_col_r, b2_col_r, out_col_r;
  logic                      b1_eof_r, b2_eof_r, out_eof_r;

  logic [bb3_pkg::SUM_W-1:0] sum     [3];
  logic [bb3_pkg::SUM_W-1:0] b2_sum_r[3];
  logic [PROD_W-1:0]         prod    [3];
  logic [7:0]                mean_r  [3];

  // whole back pipeline moves when the output register is free or drained
  assign adv = !out_v_r || out_ready;
  assign pop = adv && pop_valid;

  // window: row 0 two lines up, row 2 current, column 2 newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (pop) begin
      for (int k = 0; k < 3; k++) begin
        win_r[3*k]   <= win_r[3*k+1];
        win_r[3*k+1] <= win_r[3*k+2];
      end
      win_r[2] <= pop_word.above2;
      win_r[5] <= pop_word.above1;
      win_r[8] <= pop_word.pix;
    end
  end

  // nine-sample sum per channel over the current window
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int i = 0; i < 9; i++)
        sum[ch] = sum[ch] + bb3_pkg::SUM_W'(win_r[i][8*ch +: 8]);
    end
  end

  // divide by nine via reciprocal multiply
  always_comb begin
    for (int ch = 0; ch < 3; ch++)
      prod[ch] = PROD_W'(b2_sum_r[ch]) * PROD_W'(bb3_pkg::RECIP9);
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= pop && pop_word.emit;
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_row_r  <= pop_word.row;
      b1_col_r  <= pop_word.col;
      b1_eof_r  <= pop_word.eof;
      b2_row_r  <= b1_row_r;
      b2_col_r  <= b1_col_r;
      b2_eof_r  <= b1_eof_r;
      out_row_r <= b2_row_r;
      out_col_r <= b2_col_r;
      out_eof_r <= b2_eof_r;
      for (int ch = 0; ch < 3; ch++) begin
        b2_sum_r[ch] <= sum[ch];
        mean_r[ch]   <= prod[ch][bb3_pkg::RECIP_SH +: 8];
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_mean_blue    = mean_r[0];
  assign out_mean_green   = mean_r[1];
  assign out_mean_red     = mean_r[2];
  assign out_center_row   = out_row_r;
  assign out_center_col   = out_col_r;
  assign out_end_of_frame = out_eof_r;

endmodule

// ===== rtl/box_blur_3x3_rgb.sv =====
// Top level of the 3x3 RGB box blur.
// Instantiates bb3_front, bb3_fifo and bb3_back; uses bb3_pkg.
//
// Usage:
//   in_*  : raster-order pixels, one word per valid/ready handshake.
//           in_start_of_frame marks row 0, column 0 and restarts the counters.
//   out_* : one word per interior pixel (not on the first or last row or
//           column): floor of the 3x3 sum / 9 per channel, with the center
//           position; out_end_of_frame flags the last result of a frame.
//   cfg_* : index 0 = image width (clamped to 3..2048), index 1 = image
//           height (clamped to 3..4095). Write only while the block is idle.
// Throughput: one pixel per cycle while in_ready is high, set by the line
//   store, which takes the read for the accepted pixel and the write-back of
//   the previous one each cycle.
// Result path: line store read, queue, sum, divide.
// Reset: counters, queue and pipeline clear; geometry returns to 640x480.
//   Line store contents are undefined until written by the first frame.
// Stall: when out_ready is low the back end holds its result; the front keeps
//   accepting into a 4-word queue and drops in_ready when it fills.
module box_blur_3x3_rgb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_pix_blue,
  input  logic [7:0]                 in_pix_green,
  input  logic [7:0]                 in_pix_red,
  input  logic                       in_start_of_frame,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_mean_blue,
  output logic [7:0]                 out_mean_green,
  output logic [7:0]                 out_mean_red,
  output logic [bb3_pkg::ROW_W-1:0]  out_center_row,
  output logic [bb3_pkg::COL_W-1:0]  out_center_col,
  output logic                       out_end_of_frame,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]  cfg_data
);

  logic                        push_valid, pop, pop_valid;
  bb3_pkg::q_word_t            push_word, pop_word;
  logic [bb3_pkg::QCNT_W-1:0]  q_count;

  // accept, count and fetch line data
  bb3_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pix_blue       (in_pix_blue),
    .in_pix_green      (in_pix_green),
    .in_pix_red        (in_pix_red),
    .in_start_of_frame (in_start_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_count           (q_count),
    .push_valid        (push_valid),
    .push_word         (push_word)
  );

  // decoupling queue
  bb3_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_word   (pop_word),
    .count      (q_count)
  );

  // window and mean
  bb3_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_word         (pop_word),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_blue    (out_mean_blue),
    .out_mean_green   (out_mean_green),
    .out_mean_red     (out_mean_red),
    .out_center_row   (out_center_row),
    .out_center_col   (out_center_col),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ===== rtl/bb3_checker.sv =====
// Port-level checker for box_blur_3x3_rgb, bound to the top level.
// Uses box_blur_3x3_rgb_macros.svh and bb3_pkg widths.
`include "box_blur_3x3_rgb_macros.svh"

module bb3_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [7:0]                 out_mean_blue,
  input logic [7:0]                 out_mean_green,
  input logic [7:0]                 out_mean_red,
  input logic [bb3_pkg::ROW_W-1:0]  out_center_row,
  input logic [bb3_pkg::COL_W-1:0]  out_center_col,
  input logic                       out_end_of_frame
);

  // stalled result word holds
  `BB3_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_mean_blue) && $stable(out_mean_green) && $stable(out_mean_red) && $stable(out_center_row) && $stable(out_center_col) && $stable(out_end_of_frame), "result word changed while stalled")

  // no result in the cycle right after reset
  `BB3_ASSERT(a_out_reset, clk, rst_n, !$past(rst_n) |-> !out_valid, "result valid right after reset")

  // no result for row 0 or column 0
  `BB3_ASSERT(a_interior, clk, rst_n, out_valid |-> (out_center_row != '0) && (out_center_col != '0), "result for a border position")

  // a first result rises no sooner than a pixel accepted after reset can pass the pipeline
  `BB3_ASSERT(a_latency, clk, rst_n, $rose(out_valid) |-> $past(rst_n, 4), "result too soon after reset")

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_mean_blue    (out_mean_blue),
  .out_mean_green   (out_mean_green),
  .out_mean_red     (out_mean_red),
  .out_center_row   (out_center_row),
  .out_center_col   (out_center_col),
  .out_end_of_frame (out_end_of_frame)
);

// ===== tb/box_blur_3x3_rgb_tb.sv =====
// Self-checking testbench for box_blur_3x3_rgb: directed rows, geometry extremes and
// random frames, checked against an in-bench 3x3 mean blur model or typed results.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL only.
module box_blur_3x3_rgb_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_PIXELS   = 360;

  // One result word as seen on the out_ side
  typedef struct packed {
    logic [7:0]                mean_blue;
    logic [7:0]                mean_green;
    logic [7:0]                mean_red;
    logic [bb3_pkg::ROW_W-1:0] center_row;
    logic [bb3_pkg::COL_W-1:0] center_col;
    logic                      end_of_frame;
  } blur_res_t;

  // Directed stimulus rows
  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_REG,
    ROW_SETTLE
  } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    bb3_pkg::cfg_reg_t idx;
    logic [11:0]       data;
    logic [23:0]       pix;
    logic              sof;
    bit                typed;
    blur_res_t         tres;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_pix_blue = '0;
  logic [7:0]                in_pix_green = '0;
  logic [7:0]                in_pix_red = '0;
  logic                      in_start_of_frame = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                out_mean_blue;
  logic [7:0]                out_mean_green;
  logic [7:0]                out_mean_red;
  logic [bb3_pkg::ROW_W-1:0] out_center_row;
  logic [bb3_pkg::COL_W-1:0] out_center_col;
  logic                      out_end_of_frame;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [0:0]                cfg_index = '0;
  logic [bb3_pkg::CFG_W-1:0] cfg_data = '0;

  // Bench state
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  bit        cur_typed = 1'b0;
  blur_res_t cur_typed_res = '0;
  blur_res_t awaited_blurs[$];
  dir_row_t  dir_rows[$];

  // Blur model state
  logic [bb3_pkg::CFG_W-1:0] geo_w = bb3_pkg::RST_WIDTH;
  logic [bb3_pkg::CFG_W-1:0] geo_h = bb3_pkg::RST_HEIGHT;
  logic [23:0]               older_line[bb3_pkg::MAX_WIDTH];
  logic [23:0]               newer_line[bb3_pkg::MAX_WIDTH];
  logic [23:0]               win[9];
  logic [bb3_pkg::ROW_W-1:0] row_cnt = '0;
  logic [bb3_pkg::COL_W-1:0] col_cnt = '0;

  box_blur_3x3_rgb dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pix_blue       (in_pix_blue),
    .in_pix_green      (in_pix_green),
    .in_pix_red        (in_pix_red),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_blue     (out_mean_blue),
    .out_mean_green    (out_mean_green),
    .out_mean_red      (out_mean_red),
    .out_center_row    (out_center_row),
    .out_center_col    (out_center_col),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    foreach (older_line[k]) begin
      older_line[k] = '0;
      newer_line[k] = '0;
    end
    foreach (win[k]) win[k] = '0;
  end

  function automatic int clamp_w(int v);
    if (v < 3) return 3;
    if (v > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
    return v;
  endfunction

  // Advance the blur model by one pixel; returns 1 when a result is due
  function automatic bit blur_step(input logic [23:0] pix, input logic sof,
                                   output blur_res_t res);
    int w, h, r, c, k, sb, sg, sr;
    logic [23:0] a2, a1;
    w = clamp_w(geo_w);
    h = (geo_h < 3) ? 3 : geo_h;
    if (sof) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    r = row_cnt;
    c = col_cnt;
    a2 = older_line[c];
    a1 = newer_line[c];
    older_line[c] = a1;
    newer_line[c] = pix;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = a2;
    win[5] = a1;
    win[8] = pix;
    res = '0;
    blur_step = 1'b0;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      sb = 0;
      sg = 0;
      sr = 0;
      for (k = 0; k < 9; k++) begin
        sb += win[k][7:0];
        sg += win[k][15:8];
        sr += win[k][23:16];
      end
      res.mean_blue    = 8'(sb / 9);
      res.mean_green   = 8'(sg / 9);
      res.mean_red     = 8'(sr / 9);
      res.center_row   = bb3_pkg::ROW_W'(r - 1);
      res.center_col   = bb3_pkg::COL_W'(c - 1);
      res.end_of_frame = (r == h - 1) && (c == w - 1);
      blur_step = 1'b1;
    end
    // raster counters
    if (c + 1 >= w) begin
      col_cnt = '0;
      row_cnt = (r + 1 >= h) ? '0 : bb3_pkg::ROW_W'(r + 1);
    end else begin
      col_cnt = bb3_pkg::COL_W'(c + 1);
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] rand_byte();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] rand_pix();
    return {rand_byte(), rand_byte(), rand_byte()};
  endfunction

  // mostly small frames, a few clamped or wider ones
  function automatic int pick_dim(int hi);
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return $urandom_range(0, 2);
    if (p < 8) return $urandom_range(3, hi);
    return $urandom_range(hi + 1, 32);
  endfunction

  function automatic dir_row_t pix_row(logic [23:0] pix, logic sof, bit typed,
                                       blur_res_t tres);
    dir_row_t d;
    d.kind  = ROW_PIXEL;
    d.idx   = bb3_pkg::REG_IMAGE_WIDTH;
    d.data  = '0;
    d.pix   = pix;
    d.sof   = sof;
    d.typed = typed;
    d.tres  = tres;
    return d;
  endfunction

  function automatic dir_row_t ctl_row(row_kind_t kind, bb3_pkg::cfg_reg_t idx,
                                       logic [11:0] data);
    dir_row_t d;
    d.kind  = kind;
    d.idx   = idx;
    d.data  = data;
    d.pix   = '0;
    d.sof   = 1'b0;
    d.typed = 1'b0;
    d.tres  = '0;
    return d;
  endfunction

  task automatic chk_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Offer one pixel word and wait until it is taken
  task automatic send_pix(logic [23:0] pix, logic sof, bit typed, blur_res_t tres);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_pix_blue       <= pix[7:0];
    in_pix_green      <= pix[15:8];
    in_pix_red        <= pix[23:16];
    in_start_of_frame <= sof;
    cur_typed     = typed;
    cur_typed_res = tres;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(bb3_pkg::cfg_reg_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every awaited result drain, then allow for pipeline tail
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_blurs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold on request
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 80) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        out_ready <= 1'b0;
      end
    end
  end

  // Accepted words: update model on the input side, compare on the output side
  always @(posedge clk) begin : mon
    blur_res_t pred, want;
    bit        got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH) geo_w = cfg_data;
        else geo_h = cfg_data;
      end
      if (in_valid && in_ready) begin
        got = blur_step({in_pix_red, in_pix_green, in_pix_blue}, in_start_of_frame, pred);
        if (cur_typed) awaited_blurs.push_back(cur_typed_res);
        else if (got) awaited_blurs.push_back(pred);
      end
      if (out_valid && out_ready) begin
        if (awaited_blurs.size() == 0) begin
          $display("%0t: result expected none, got row %0d col %0d", $time,
                   out_center_row, out_center_col);
          err_cnt++;
        end else begin
          want = awaited_blurs.pop_front();
          chk_field("mean_blue", want.mean_blue, out_mean_blue);
          chk_field("mean_green", want.mean_green, out_mean_green);
          chk_field("mean_red", want.mean_red, out_mean_red);
          chk_field("center_row", want.center_row, out_center_row);
          chk_field("center_col", want.center_col, out_center_col);
          chk_field("end_of_frame", want.end_of_frame, out_end_of_frame);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int        i, nw, nh, new_eff, cur_eff_w, n_items, phase_no, rand_pix_cnt;
    bit        need_sof, wr_w;
    blur_res_t all_max, all_min, none;

    all_max = '{8'd255, 8'd255, 8'd255, 12'd1, 11'd1, 1'b1};
    all_min = '{8'd0, 8'd0, 8'd0, 12'd1, 11'd1, 1'b1};
    none    = '0;

    // Directed rows: clamped 3x3 frames at both extremes, counter wrap,
    // restart mid-frame, then a width shrink while a line is in progress
    dir_rows.push_back(ctl_row(ROW_REG, bb3_pkg::REG_IMAGE_WIDTH, 12'd0));
    dir_rows.push_back(ctl_row(ROW_REG, bb3_pkg::REG_IMAGE_HEIGHT, 12'd2));
    for (i = 0; i < 9; i++) dir_rows.push_back(pix_row(24'hFFFFFF, i == 0, i == 8, all_max));
    // no start flag: the counters wrapped after the last frame
    for (i = 0; i < 9; i++) dir_rows.push_back(pix_row(24'h000000, 1'b0, i == 8, all_min));
    dir_rows.push_back(ctl_row(ROW_SETTLE, bb3_pkg::REG_IMAGE_WIDTH, 12'd0));
    dir_rows.push_back(ctl_row(ROW_REG, bb3_pkg::REG_IMAGE_WIDTH, 12'd4));
    dir_rows.push_back(ctl_row(ROW_REG, bb3_pkg::REG_IMAGE_HEIGHT, 12'd4));
    dir_rows.push_back(pix_row(24'h5A3C1E, 1'b0, 1'b0, none));
    for (i = 0; i < 15; i++) begin
      dir_rows.push_back(pix_row({(i % 2) ? 8'hFF : 8'h00, 8'(255 - i * 17), 8'(i * 17)},
                                 i == 0, 1'b0, none));
    end
    // row 3 stopped at column 3; width drops to 3 so that pixel is past the edge
    dir_rows.push_back(ctl_row(ROW_SETTLE, bb3_pkg::REG_IMAGE_WIDTH, 12'd0));
    dir_rows.push_back(ctl_row(ROW_REG, bb3_pkg::REG_IMAGE_WIDTH, 12'd3));
    dir_rows.push_back(pix_row(24'h808080, 1'b0, 1'b0, none));

    // Reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default 640x480 geometry straight out of reset: part of row 0, no results
    for (i = 0; i < 24; i++) send_pix(rand_pix(), 1'b0, 1'b0, none);
    settle();

    foreach (dir_rows[j]) begin
      case (dir_rows[j].kind)
        ROW_PIXEL: begin
          send_pix(dir_rows[j].pix, dir_rows[j].sof, dir_rows[j].typed, dir_rows[j].tres);
        end
        ROW_REG: begin
          write_reg(dir_rows[j].idx, dir_rows[j].data);
        end
        default: begin
          settle();
        end
      endcase
    end
    settle();

    // Widest line (clamped from all ones), shortest frame: start of row 0 only
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 12'h000);
    for (i = 0; i < 40; i++) send_pix(rand_pix(), i == 0, 1'b0, none);
    settle();

    // Narrowest line, tallest frame
    write_reg(bb3_pkg::REG_IMAGE_WIDTH, 12'd3);
    write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
    for (i = 0; i < 30; i++) send_pix(rand_pix(), i == 0, 1'b0, none);
    settle();

    // Random phases of small frames
    cur_eff_w = 3;
    phase_no = 0;
    rand_pix_cnt = 0;
    while (rand_pix_cnt < RAND_PIXELS) begin
      phase_no++;
      calm = ($urandom_range(0, 3) == 0);
      if (phase_no == 2) begin
        // long receiver hold while pixels keep coming: input must stall
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 12'd3);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 12'd8);
        cur_eff_w = 3;
        need_sof = 1'b1;
        n_items = 80;
        calm = 1'b1;
        hold_req = 1'b1;
      end else begin
        new_eff = cur_eff_w;
        wr_w = ($urandom_range(0, 9) < 7);
        if (wr_w) begin
          nw = pick_dim(8);
          write_reg(bb3_pkg::REG_IMAGE_WIDTH, 12'(nw));
          new_eff = clamp_w(nw);
        end
        if ($urandom_range(0, 9) < 7) begin
          nh = pick_dim(7);
          write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 12'(nh));
        end
        // a wider line needs a fresh frame so no unwritten store entry is read;
        // otherwise the frame may carry on under the new geometry
        need_sof = (new_eff > cur_eff_w) || ($urandom_range(0, 1) == 1);
        cur_eff_w = new_eff;
        n_items = $urandom_range(12, 70);
      end
      for (i = 0; i < n_items; i++) begin
        send_pix(rand_pix(), (i == 0 && need_sof) || ($urandom_range(0, 49) == 0),
                 1'b0, none);
        rand_pix_cnt++;
      end
      settle();
    end
    calm = 1'b0;

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
